// ===== design/sdq_pkg.sv =====
package sdq_pkg;

  // fixed field widths
  localparam int VALUE_W             = 32;
  localparam int ACTION_W            = 3;
  localparam int COUNT_OUT_W         = 7;
  localparam int STATUS_W            = 2;
  localparam int DEFAULT_QUEUE_DEPTH = 64;

  // request codes on the action port
  localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_SORT       = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // decoded operation handed from front to back
  typedef enum logic [2:0] {
    OP_PUSH_BACK,
    OP_PUSH_FRONT,
    OP_POP_BACK,
    OP_POP_FRONT,
    OP_SORT,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                        op;
    logic signed [VALUE_W-1:0]  value;
  } cmd_t;

endpackage

// ===== design/sdq_front.sv =====
module sdq_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [sdq_pkg::ACTION_W-1:0]         action,
  input  logic signed [sdq_pkg::VALUE_W-1:0]   push_value,
  input  logic                                 fifo_full,
  output logic                                 busy,
  output logic                                 cmd_push,
  output sdq_pkg::cmd_t                        cmd
);
  import sdq_pkg::*;

  logic  front_valid;
  logic  accept;
  op_t   op_dec;

  // hold off new words only when the staged command cannot move on
  assign busy     = front_valid & fifo_full;
  assign accept   = start & ~busy;
  assign cmd_push = front_valid & ~fifo_full;

  // classify the request
  always_comb begin
    unique case (action)
      ACT_PUSH_BACK:  op_dec = OP_PUSH_BACK;
      ACT_PUSH_FRONT: op_dec = OP_PUSH_FRONT;
      ACT_POP_BACK:   op_dec = OP_POP_BACK;
      ACT_POP_FRONT:  op_dec = OP_POP_FRONT;
      ACT_SORT:       op_dec = OP_SORT;
      default:        op_dec = OP_NOP;
    endcase
  end

  // staging register
  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (accept) begin
      front_valid <= 1'b1;
    end else if (cmd_push) begin
      front_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd.op    <= op_dec;
      cmd.value <= push_value;
    end
  end

endmodule

// ===== design/sdq_cmd_fifo.sv =====
module sdq_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  sdq_pkg::cmd_t  wr_cmd,
  output logic           full,
  input  logic           rd_en,
  output sdq_pkg::cmd_t  rd_cmd,
  output logic           empty
);
  import sdq_pkg::*;

  // two-entry command queue between front and back
  cmd_t        slots [2];
  logic        wptr;
  logic        rptr;
  logic [1:0]  fill;

  assign full   = (fill == 2'd2);
  assign empty  = (fill == 2'd0);
  assign rd_cmd = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (wr_en) wptr <= ~wptr;
      if (rd_en) rptr <= ~rptr;
      unique case ({wr_en, rd_en})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) slots[wptr] <= wr_cmd;
  end

endmodule

// ===== design/sdq_back.sv =====
module sdq_back #(
  parameter int QUEUE_DEPTH = sdq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cmd_valid,
  input  sdq_pkg::cmd_t                        cmd,
  output logic                                 cmd_take,
  output logic                                 done,
  output logic signed [sdq_pkg::VALUE_W-1:0]   popped_value,
  output logic [sdq_pkg::COUNT_OUT_W-1:0]      entry_count,
  output logic [sdq_pkg::STATUS_W-1:0]         status
);
  import sdq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW:0]   DEPTH_V = (AW+1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_POP_WAIT = 3'd1;
  localparam logic [2:0] S_KEY_RD   = 3'd2;
  localparam logic [2:0] S_KEY_LAT  = 3'd3;
  localparam logic [2:0] S_CMP      = 3'd4;
  localparam logic [2:0] S_PLACE    = 3'd5;

  // ring storage
  logic [VALUE_W-1:0]        mem [QUEUE_DEPTH];
  logic signed [VALUE_W-1:0] rd_data;
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [VALUE_W-1:0]        mem_wdata;
  logic                      mem_re;
  logic [AW-1:0]             mem_raddr;

  logic [2:0]                state, state_next;
  logic [AW-1:0]             front, front_next;
  logic [CW-1:0]             count, count_next;
  logic [CW-1:0]             sort_i, sort_i_next;
  logic [CW-1:0]             sort_j, sort_j_next;
  logic signed [VALUE_W-1:0] key, key_next;

  logic                      res_valid;
  logic signed [VALUE_W-1:0] res_popped;
  logic [CW-1:0]             res_count;
  logic [STATUS_W-1:0]       res_status;
  logic                      advance;

  logic [CW-1:0]             count_m1;
  logic [CW-1:0]             j_m1;
  logic [CW-1:0]             j_m2;

  // front plus offset, wrapped once around the ring
  function automatic logic [AW-1:0] ring_slot(input logic [AW-1:0] base,
                                              input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= DEPTH_V) s = s - DEPTH_V;
    return s[AW-1:0];
  endfunction

  assign count_m1 = count - CW'(1);
  assign j_m1     = sort_j - CW'(1);
  assign j_m2     = sort_j - CW'(2);

  // sequencer: one request at a time, sort runs as insertion passes
  always_comb begin
    state_next  = state;
    front_next  = front;
    count_next  = count;
    sort_i_next = sort_i;
    sort_j_next = sort_j;
    key_next    = key;
    mem_we      = 1'b0;
    mem_waddr   = ring_slot(front, sort_j[AW-1:0]);
    mem_wdata   = key;
    mem_re      = 1'b0;
    mem_raddr   = front;
    cmd_take    = 1'b0;
    res_valid   = 1'b0;
    res_popped  = '0;
    res_count   = count;
    res_status  = ST_OK;
    advance     = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_take = 1'b1;
          unique case (cmd.op)
            OP_PUSH_BACK: begin
              res_valid = 1'b1;
              if (count >= DEPTH_C) begin
                res_status = ST_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = ring_slot(front, count[AW-1:0]);
                mem_wdata  = cmd.value;
                count_next = count + CW'(1);
                res_count  = count + CW'(1);
              end
            end
            OP_PUSH_FRONT: begin
              res_valid = 1'b1;
              if (count >= DEPTH_C) begin
                res_status = ST_FULL;
              end else begin
                front_next = (front == '0) ? LAST_SLOT : front - AW'(1);
                mem_we     = 1'b1;
                mem_waddr  = front_next;
                mem_wdata  = cmd.value;
                count_next = count + CW'(1);
                res_count  = count + CW'(1);
              end
            end
            OP_POP_BACK: begin
              if (count == '0) begin
                res_valid  = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = ring_slot(front, count_m1[AW-1:0]);
                count_next = count_m1;
                state_next = S_POP_WAIT;
              end
            end
            OP_POP_FRONT: begin
              if (count == '0) begin
                res_valid  = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = front;
                front_next = ring_slot(front, AW'(1));
                count_next = count_m1;
                state_next = S_POP_WAIT;
              end
            end
            OP_SORT: begin
              if (count < CW'(2)) begin
                res_valid = 1'b1;
              end else begin
                sort_i_next = CW'(1);
                state_next  = S_KEY_RD;
              end
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end
      S_POP_WAIT: begin
        res_valid  = 1'b1;
        res_popped = rd_data;
        state_next = S_IDLE;
      end
      // fetch the key of this pass
      S_KEY_RD: begin
        mem_re      = 1'b1;
        mem_raddr   = ring_slot(front, sort_i[AW-1:0]);
        sort_j_next = sort_i;
        state_next  = S_KEY_LAT;
      end
      S_KEY_LAT: begin
        key_next   = rd_data;
        mem_re     = 1'b1;
        mem_raddr  = ring_slot(front, j_m1[AW-1:0]);
        state_next = S_CMP;
      end
      // shift larger neighbors up by one until the key fits
      S_CMP: begin
        mem_we = 1'b1;
        if (rd_data > key) begin
          mem_wdata   = rd_data;
          sort_j_next = j_m1;
          if (j_m1 == '0) begin
            state_next = S_PLACE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = ring_slot(front, j_m2[AW-1:0]);
          end
        end else begin
          advance = 1'b1;
        end
      end
      S_PLACE: begin
        mem_we  = 1'b1;
        advance = 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // end of one insertion pass
    if (advance) begin
      if (sort_i + CW'(1) == count) begin
        res_valid  = 1'b1;
        state_next = S_IDLE;
      end else begin
        sort_i_next = sort_i + CW'(1);
        state_next  = S_KEY_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
      done  <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    sort_i       <= sort_i_next;
    sort_j       <= sort_j_next;
    key          <= key_next;
    popped_value <= res_popped;
    entry_count  <= COUNT_OUT_W'(res_count);
    status       <= res_status;
  end

  // single write port, single registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data <= mem[mem_raddr];
  end

endmodule

// ===== design/sortable_double_ended_queue.sv =====
// A request goes through the front staging register and the command queue to the back end.
// Throughput: the back end retires a push per cycle while commands wait; a pop waits on the
// registered RAM read and a sort holds it for all its insertion passes (one RAM port each way).
// A two-word command queue takes start while the back end works; busy rises when it is full
// with a command staged. Each result shows for one cycle on done; the receiver cannot stall.
// Synchronous reset empties the queue; stored values are not cleared.
module sortable_double_ended_queue #(
  parameter int QUEUE_DEPTH = sdq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [sdq_pkg::ACTION_W-1:0]         action,
  input  logic signed [sdq_pkg::VALUE_W-1:0]   push_value,
  output logic                                 done,
  output logic signed [sdq_pkg::VALUE_W-1:0]   popped_value,
  output logic [sdq_pkg::COUNT_OUT_W-1:0]      entry_count,
  output logic [sdq_pkg::STATUS_W-1:0]         status
);
  import sdq_pkg::*;

  cmd_t  front_cmd;
  cmd_t  head_cmd;
  logic  cmd_push;
  logic  cmd_take;
  logic  fifo_full;
  logic  fifo_empty;

  // request decode and staging
  sdq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .action     (action),
    .push_value (push_value),
    .fifo_full  (fifo_full),
    .busy       (busy),
    .cmd_push   (cmd_push),
    .cmd        (front_cmd)
  );

  sdq_cmd_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (cmd_push),
    .wr_cmd (front_cmd),
    .full   (fifo_full),
    .rd_en  (cmd_take),
    .rd_cmd (head_cmd),
    .empty  (fifo_empty)
  );

  // execution against the ring
  sdq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (~fifo_empty),
    .cmd          (head_cmd),
    .cmd_take     (cmd_take),
    .done         (done),
    .popped_value (popped_value),
    .entry_count  (entry_count),
    .status       (status)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !fifo_full)
    else $error("command queue written while full");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> !fifo_empty)
    else $error("back end took a command from an empty queue");

  a_err_no_value: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> popped_value == '0)
    else $error("error result carries a popped value");
`endif

endmodule
